// ===== rtl/u8e_pkg.sv =====
// Shared types, constants and helper functions for the UTF-8 encoder.
// This package has no dependencies. Every module of the block imports it.
package u8e_pkg;

  // Request on the input channel: one code point and its string flag.
  typedef struct packed {
    logic [30:0] code_point;
    logic        string_start;
  } in_req_t;

  // Request on the output channel: one encoded byte.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       char_done;
  } out_req_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CfgLimitEnable = 1'b0,
    CfgByteLimit   = 1'b1
  } cfg_idx_e;

  // Encoded length in bytes, from one to six.
  typedef logic [2:0] len_t;

  // One classified character waiting for the byte serializer.
  typedef struct packed {
    logic [30:0] code_point;
    len_t        len;
  } char_entry_t;

  // Write side of the character queue.
  typedef struct packed {
    logic        push;
    char_entry_t entry;
  } q_wr_t;

  // Read side of the character queue.
  typedef struct packed {
    logic        empty;
    char_entry_t head;
  } q_rd_t;

  // Queue sizing.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;

  // Range thresholds for the encoded length.
  localparam logic [30:0] Lim2 = 31'h0000_0080;
  localparam logic [30:0] Lim3 = 31'h0000_0800;
  localparam logic [30:0] Lim4 = 31'h0001_0000;
  localparam logic [30:0] Lim5 = 31'h0020_0000;
  localparam logic [30:0] Lim6 = 31'h0400_0000;

  // Lead byte prefixes and the continuation marker.
  localparam logic [7:0] Lead2    = 8'd192;
  localparam logic [7:0] Lead3    = 8'd224;
  localparam logic [7:0] Lead4    = 8'd240;
  localparam logic [7:0] Lead5    = 8'd248;
  localparam logic [7:0] Lead6    = 8'd252;
  localparam logic [7:0] ContMark = 8'h80;
  localparam logic [5:0] SixMask  = 6'd63;

  // Number of bytes a code point takes.
  function automatic len_t enc_length(logic [30:0] cp);
    len_t n;
    if (cp < Lim2) begin
      n = 3'd1;
    end else if (cp < Lim3) begin
      n = 3'd2;
    end else if (cp < Lim4) begin
      n = 3'd3;
    end else if (cp < Lim5) begin
      n = 3'd4;
    end else if (cp < Lim6) begin
      n = 3'd5;
    end else begin
      n = 3'd6;
    end
    return n;
  endfunction

  // Prefix of the lead byte for a multi-byte length.
  function automatic logic [7:0] lead_prefix(len_t n);
    logic [7:0] p;
    unique case (n)
      3'd2:    p = Lead2;
      3'd3:    p = Lead3;
      3'd4:    p = Lead4;
      3'd5:    p = Lead5;
      default: p = Lead6;
    endcase
    return p;
  endfunction

  // Six-bit group number d of a code point, counted from the low end.
  function automatic logic [5:0] six_bits(logic [30:0] cp, len_t d);
    logic [35:0] ext;
    logic [5:0]  g;
    ext = {5'b0, cp};
    unique case (d)
      3'd0:    g = ext[5:0];
      3'd1:    g = ext[11:6];
      3'd2:    g = ext[17:12];
      3'd3:    g = ext[23:18];
      3'd4:    g = ext[29:24];
      3'd5:    g = ext[35:30];
      default: g = '0;
    endcase
    return g & SixMask;
  endfunction

  // Byte k of the n-byte encoding of a code point.
  function automatic logic [7:0] enc_byte(logic [30:0] cp, len_t n, len_t k);
    logic [5:0] g;
    logic [7:0] b;
    g = six_bits(cp, len_t'(n - 3'd1 - k));
    if (n == 3'd1) begin
      b = {1'b0, cp[6:0]};
    end else if (k == 3'd0) begin
      b = lead_prefix(n) | {2'b0, g};
    end else begin
      b = ContMark | {2'b0, g};
    end
    return b;
  endfunction

endpackage

// ===== rtl/u8e_front.sv =====
// Front end of the UTF-8 encoder: configuration registers, length
// classification and the per-string byte budget. Depends on u8e_pkg.
module u8e_front import u8e_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  cfg_idx_e    cfg_idx_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  in_req_t     in_req_i,
  output logic        in_stall_o,
  input  logic        q_full_i,
  output q_wr_t       q_wr_o
);

  logic        limit_en_q;
  logic [30:0] byte_limit_q;
  logic [31:0] used_q, used_d;
  logic        stopped_q, stopped_d;

  logic        accept;
  logic [31:0] eff_used;
  logic        eff_stop;
  len_t        n;
  logic [32:0] total;
  logic        over;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_en_q   <= 1'b0;
      byte_limit_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLimitEnable: limit_en_q   <= cfg_wdata_i[0];
        CfgByteLimit:   byte_limit_q <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // Accept a request whenever the queue has room.
  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  // A string start clears the count and the stop before the budget check.
  assign eff_used = in_req_i.string_start ? 32'd0 : used_q;
  assign eff_stop = in_req_i.string_start ? 1'b0 : stopped_q;
  assign n        = enc_length(in_req_i.code_point);
  assign total    = {1'b0, eff_used} + {30'd0, n};
  assign over     = limit_en_q && (total > {2'b0, byte_limit_q});

  // Budget state update and queue push.
  always_comb begin
    used_d              = used_q;
    stopped_d           = stopped_q;
    q_wr_o.push         = 1'b0;
    q_wr_o.entry.code_point = in_req_i.code_point;
    q_wr_o.entry.len    = n;
    if (accept) begin
      if (eff_stop || over) begin
        used_d    = eff_used;
        stopped_d = 1'b1;
      end else begin
        used_d      = total[32] ? 32'hFFFF_FFFF : total[31:0];
        stopped_d   = 1'b0;
        q_wr_o.push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      stopped_q <= 1'b0;
    end else begin
      used_q    <= used_d;
      stopped_q <= stopped_d;
    end
  end

endmodule

// ===== rtl/u8e_queue.sv =====
// Short character queue between the front end and the byte serializer.
// Depends on u8e_pkg for the entry type and the depth.
module u8e_queue import u8e_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  q_wr_t  q_wr_i,
  input  logic   pop_i,
  output logic   full_o,
  output q_rd_t  q_rd_o
);

  char_entry_t        mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               do_pop;

  assign full_o         = (cnt_q == QCntW'(QDepth));
  assign q_rd_o.empty   = (cnt_q == '0);
  assign q_rd_o.head    = mem_q[rd_ptr_q];
  assign do_pop         = pop_i && !q_rd_o.empty;

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_d = cnt_q;
    if (q_wr_i.push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!q_wr_i.push && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (q_wr_i.push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Entry storage; payload only, no reset.
  always_ff @(posedge clk_i) begin
    if (q_wr_i.push) begin
      mem_q[wr_ptr_q] <= q_wr_i.entry;
    end
  end

endmodule

// ===== rtl/u8e_back.sv =====
// Back end of the UTF-8 encoder: walks the queue head byte by byte into
// an output register. Depends on u8e_pkg.
module u8e_back import u8e_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_rd_t    q_rd_i,
  output logic     pop_o,
  output logic     out_valid_o,
  output out_req_t out_req_o,
  input  logic     out_stall_i
);

  len_t     k_q, k_d;
  logic     out_valid_q, out_valid_d;
  out_req_t out_q, out_d;
  logic     advance;
  logic     last;

  // The output register may load when it is empty or being taken.
  assign advance = !out_valid_q || !out_stall_i;
  assign last    = (k_q == len_t'(q_rd_i.head.len - 3'd1));
  assign pop_o   = advance && !q_rd_i.empty && last;

  // Next byte of the head character.
  always_comb begin
    k_d                = k_q;
    out_valid_d        = out_valid_q;
    out_d.out_byte     = enc_byte(q_rd_i.head.code_point, q_rd_i.head.len, k_q);
    out_d.char_done    = last;
    if (advance) begin
      out_valid_d = !q_rd_i.empty;
      if (!q_rd_i.empty) begin
        k_d = last ? 3'd0 : len_t'(k_q + 3'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload, loaded only with a fresh byte.
  always_ff @(posedge clk_i) begin
    if (advance && !q_rd_i.empty) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // The byte index stays inside the head character.
  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_rd_i.empty |-> (k_q < q_rd_i.head.len))
    else $error("byte index beyond character length");

  // Part of a character is out only while its entry is still queued.
  a_mid_char_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q != 3'd0) |-> !q_rd_i.empty)
    else $error("character entry left the queue mid-run");

  // Retiring an entry shows its final byte next.
  a_pop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && out_q.char_done))
    else $error("entry retired without a final byte");

  // A byte loaded without retiring the entry is not the final one.
  a_mid_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !q_rd_i.empty && !pop_o) |=> (out_valid_q && !out_q.char_done))
    else $error("final byte flagged early");

endmodule

// ===== rtl/utf8_encoder_with_byte_limit.sv =====
// UTF-8 encoder, original one-to-six-byte form, with an optional byte
// budget per string. The input takes one code point per cycle while the
// four-entry character queue has room; requests that are dropped by the
// budget are taken at the same rate and leave nothing in the queue. The
// output register gives one byte per cycle while out_stall_i is low and
// the queue holds a character, so sustained throughput is set by the byte
// serializer, which sends each character one byte at a time. The first
// byte of an accepted request is written into the queue and then loaded
// into the output register. Configuration is written through cfg_we_i,
// index 0 enabling the budget and index 1 holding the byte limit. Depends
// on u8e_pkg, u8e_front, u8e_queue and u8e_back.
module utf8_encoder_with_byte_limit import u8e_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  cfg_idx_e    cfg_idx_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  in_req_t     in_req_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  output out_req_t    out_req_o,
  input  logic        out_stall_i
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // Classification and budget.
  u8e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .q_wr_o      (q_wr)
  );

  // Decoupling queue.
  u8e_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_wr_i (q_wr),
    .pop_i  (q_pop),
    .full_o (q_full),
    .q_rd_o (q_rd)
  );

  // Byte serializer.
  u8e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_rd_i      (q_rd),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_req_o   (out_req_o),
    .out_stall_i (out_stall_i)
  );

endmodule
